### sv/mapped_string_hash_mod_assert.svh
// assertion macros for the mapped string hash block
// used by mapped_string_hash_mod.sv, expects clk and rst in scope
`ifndef MAPPED_STRING_HASH_MOD_ASSERT_SVH
`define MAPPED_STRING_HASH_MOD_ASSERT_SVH

// same-cycle implication
`define MSHM_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("mapped_string_hash_mod: assertion failed");

// next-cycle implication
`define MSHM_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("mapped_string_hash_mod: assertion failed");

`endif

### sv/mshm_pkg.sv
// shared types and constants of the mapped string hash block
// no dependencies
`default_nettype none

package mshm_pkg;

  localparam int MAP_ENTRIES = 128;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);
  localparam int MAP_DW      = 8;
  localparam int HASH_W      = 32;

  localparam logic [HASH_W-1:0] HASH_MULT = 32'h9CCF9319;

  // action codes carried in tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // finished hash handed from the front end to the queue
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } push_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic              valid;
    logic              full;
    logic [HASH_W-1:0] hash;
  } head_t;

endpackage

`default_nettype wire

### sv/mshm_ram.sv
// generic single-port ram, registered read
// no dependencies
`default_nettype none

module mshm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### sv/mshm_front.sv
// front end: takes words, loads the character map, folds bytes into the hash
// depends on mshm_pkg and mshm_ram
`default_nettype none

module mshm_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [23:0]             s_tdata,
  input  wire logic                    s_tuser,
  input  wire logic                    q_full,
  output mshm_pkg::push_t              push
);

  logic [7:0]                    in_byte;
  logic [mshm_pkg::MAP_AW-1:0]   in_index;
  logic [mshm_pkg::MAP_DW-1:0]   in_value;
  logic                          accept;
  logic                          load;
  logic [mshm_pkg::MAP_AW-1:0]   ram_addr;
  logic [mshm_pkg::MAP_DW-1:0]   map_data;

  logic                          st_valid;
  logic [7:0]                    st_byte;
  logic                          st_term;
  logic                          st_fire;
  logic [mshm_pkg::HASH_W-1:0]   hash;
  logic [mshm_pkg::HASH_W-1:0]   byte_val;
  logic [mshm_pkg::HASH_W-1:0]   hash_mult;

  assign in_byte  = s_tdata[7:0];
  assign in_index = s_tdata[14:8];
  assign in_value = s_tdata[22:15];

  assign accept   = s_tvalid && s_tready;
  assign load     = (s_tuser == mshm_pkg::ACT_LOAD);
  assign ram_addr = load ? in_index : in_byte[mshm_pkg::MAP_AW-1:0];

  mshm_ram #(
    .WIDTH (mshm_pkg::MAP_DW),
    .DEPTH (mshm_pkg::MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (accept && load),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (map_data)
  );

  // a terminator waits here until the queue has room
  assign st_term  = (st_byte == 8'd0);
  assign st_fire  = st_valid && (!st_term || !q_full);
  assign s_tready = !st_valid || st_fire;

  // high bytes are sign-extended, low bytes go through the map
  assign byte_val  = st_byte[7] ? {24'hFFFFFF, st_byte}
                                : {{(mshm_pkg::HASH_W-mshm_pkg::MAP_DW){1'b0}}, map_data};
  assign hash_mult = hash * mshm_pkg::HASH_MULT;

  assign push.valid = st_valid && st_term && !q_full;
  assign push.hash  = hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      hash     <= '0;
    end else begin
      if (accept && !load) begin
        st_valid <= 1'b1;
      end else if (st_fire) begin
        st_valid <= 1'b0;
      end
      if (st_fire) begin
        hash <= st_term ? '0 : hash_mult + byte_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !load) begin
      st_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

### sv/mshm_queue.sv
// two-entry queue of finished hashes between front and back ends
// depends on mshm_pkg
`default_nettype none

module mshm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mshm_pkg::push_t push,
  input  wire logic            pop,
  output mshm_pkg::head_t      head
);

  logic [mshm_pkg::HASH_W-1:0] slot [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;

  assign head.valid = (count != 2'd0);
  assign head.full  = (count == 2'd2);
  assign head.hash  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[wr_ptr] <= push.hash;
    end
  end

endmodule

`default_nettype wire

### sv/mshm_back.sv
// back end: restoring divider for hash mod divisor, output register
// depends on mshm_pkg
`default_nettype none

module mshm_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [mshm_pkg::HASH_W-1:0] divisor,
  input  wire mshm_pkg::head_t             head,
  output logic                             pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [63:0]                 m_tdata
);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_DONE = 2'd2;

  localparam int DIV_STEPS = mshm_pkg::HASH_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic [1:0]                  state;
  logic [CNT_W-1:0]            cnt;
  logic [mshm_pkg::HASH_W-1:0] dividend;
  logic [mshm_pkg::HASH_W-1:0] rem;
  logic [mshm_pkg::HASH_W-1:0] dsr;
  logic [mshm_pkg::HASH_W-1:0] hash_keep;
  logic [mshm_pkg::HASH_W:0]   trial;
  logic [mshm_pkg::HASH_W:0]   diff;
  logic                        out_free;

  assign pop      = (state == BK_IDLE) && head.valid;
  assign trial    = {rem, dividend[mshm_pkg::HASH_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == BK_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          cnt <= '0;
          if (head.valid) begin
            state <= BK_DIV;
          end
        end
        BK_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (out_free) begin
            state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dividend  <= head.hash;
      hash_keep <= head.hash;
      rem       <= '0;
      dsr       <= divisor;
    end else if (state == BK_DIV) begin
      dividend <= {dividend[mshm_pkg::HASH_W-2:0], 1'b0};
      rem      <= diff[mshm_pkg::HASH_W] ? trial[mshm_pkg::HASH_W-1:0]
                                         : diff[mshm_pkg::HASH_W-1:0];
    end
    if (state == BK_DONE && out_free) begin
      // zero divisor: no reduction
      m_tdata <= {hash_keep, (dsr == '0) ? hash_keep : rem};
    end
  end

endmodule

`default_nettype wire

### sv/mapped_string_hash_mod.sv
// Mapped string hash with modulo. A front end takes one word per cycle while no
// terminator waits for queue room: map loads write the 128-entry character map,
// string bytes are folded into a 32-bit hash (h = h*0x9ccf9319 + v) at one byte
// per cycle under the same condition, low bytes read through the map and high bytes
// sign-extended. A zero byte hands the hash to a two-entry queue and clears the
// accumulator. The back end takes each hash through a bit-serial restoring
// divider and an output register; the divider is what bounds the string rate,
// while bytes of the following strings keep streaming in until the queue fills.
// Map entries must be loaded before they are used; the map has no reset.
// The divisor must be written only while the block is idle; the block itself
// does not enforce this. The divisor resets to 1.
// depends on mshm_pkg, mshm_front, mshm_queue, mshm_back and the assert header
`default_nettype none

`include "mapped_string_hash_mod_assert.svh"

module mapped_string_hash_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_byte[7:0], table_index[14:8], table_value[22:15]
  input  wire logic        s_tuser,   // action: 0 map load, 1 string byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // remainder[31:0], hash_value[63:32]
  // divisor register
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  logic [mshm_pkg::HASH_W-1:0] divisor;
  mshm_pkg::push_t             push;
  mshm_pkg::head_t             head;
  logic                        pop;

  // divisor register, plain write, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= 32'd1;
    end else if (cfg_wen) begin
      divisor <= cfg_wdata;
    end
  end

  // front end: map loads and byte folding
  mshm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (head.full),
    .push     (push)
  );

  // finished hashes waiting for the divider
  mshm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head)
  );

  // back end: modulo and output register
  mshm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .divisor  (divisor),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // the front end never pushes into a full queue
  `MSHM_ASSERT_IMPL(a_push_room, push.valid, !head.full)
  // input stalls only behind a terminator with the queue full
  `MSHM_ASSERT_IMPL(a_stall_cause, !s_tready, head.full)
  // a pushed hash is visible at the queue head next cycle
  `MSHM_ASSERT_NEXT(a_push_seen, push.valid, head.valid)
  // a reduced result stays below the divisor
  `MSHM_ASSERT_IMPL(a_rem_range, m_tvalid && (divisor != '0), m_tdata[31:0] < divisor)

endmodule

`default_nettype wire

### dv/mshm_checker.sv
`timescale 1ns / 1ps
// result checker for the mapped string hash block: follows the input, result and divisor ports,
// keeps its own map and accumulator and compares every result word with its prediction
// depends on mshm_pkg for the action codes
module mshm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          results_pending
);

  localparam logic [31:0] MIX_FACTOR = 32'h9CCF9319;

  typedef struct {
    logic [31:0] remainder;
    logic [31:0] hash_value;
  } hash_result_t;

  logic [7:0]   char_map [128];
  logic [31:0]  hash_acc;
  logic [31:0]  divisor;
  hash_result_t results_due [$];
  int           fails;

  // fold one accepted input word into the predicted state
  task automatic fold_word(input logic action, input logic [23:0] data);
    logic [7:0]   b;
    logic [31:0]  v;
    hash_result_t r;
    b = data[7:0];
    if (action == mshm_pkg::ACT_LOAD) begin
      char_map[data[14:8]] = data[22:15];
    end else if (b != 8'h00) begin
      // high bytes count as negative, low bytes go through the map
      v = b[7] ? {24'hFFFFFF, b} : {24'h000000, char_map[b[6:0]]};
      hash_acc = hash_acc * MIX_FACTOR + v;
    end else begin
      r.hash_value = hash_acc;
      r.remainder  = (divisor != 32'd0) ? hash_acc % divisor : hash_acc;
      results_due.push_back(r);
      hash_acc = 32'd0;
    end
  endtask

  task automatic check_word(input logic [63:0] data);
    hash_result_t r;
    if (results_due.size() == 0) begin
      $error("result word with none due: remainder %h hash_value %h",
             data[31:0], data[63:32]);
      fails++;
    end else begin
      r = results_due.pop_front();
      if (data[31:0] !== r.remainder) begin
        $error("remainder: expected %h actual %h", r.remainder, data[31:0]);
        fails++;
      end
      if (data[63:32] !== r.hash_value) begin
        $error("hash_value: expected %h actual %h", r.hash_value, data[63:32]);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hash_acc = 32'd0;
      divisor  = 32'd1;
      results_due.delete();
    end else begin
      if (cfg_wen) divisor = cfg_wdata;
      // results trail their terminator by many cycles, so take them first
      if (m_tvalid && m_tready) check_word(m_tdata);
      if (s_tvalid && s_tready) fold_word(s_tuser, s_tdata);
    end
    fail_count      <= fails;
    results_pending <= results_due.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// top of the mapped string hash testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on mshm_pkg, mapped_string_hash_mod and mshm_checker
module testbench;

  // settle time after the last due result, so the divider back end runs dry
  localparam int ITEM_TARGET    = 850;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // char_byte[7:0], table_index[14:8], table_value[22:15]
  logic        s_tuser;   // action: 0 map load, 1 string byte
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // remainder[31:0], hash_value[63:32]
  logic        cfg_wen;
  logic [31:0] cfg_wdata;

  int   fail_count;
  int   results_pending;

  // sender state
  int   words_sent;
  int   burst_left;
  int   idle_style;
  bit   map_loaded [128];
  // request for one long receiver hold-off
  logic hold_req;
  int   idle_cycles;

  mapped_string_hash_mod i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  mshm_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word and wait for its handshake; bursts of random length with
  // gaps between them that may be empty, their size set by the idle style of the phase
  task automatic send_word(input logic action, input logic [7:0] b,
                           input logic [6:0] idx, input logic [7:0] val);
    int gap;
    if (burst_left <= 0) begin
      case (idle_style)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 3);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {1'b0, val, idx, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // map load; char_byte is don't-care here so it gets noise, zero included
  task automatic load_entry(input logic [6:0] idx, input logic [7:0] val);
    send_word(mshm_pkg::ACT_LOAD, 8'($urandom_range(0, 255)), idx, val);
    map_loaded[idx] = 1'b1;
  endtask

  // string byte with noise in the unused fields; a low byte whose map entry
  // was never loaded gets its load first, so no undefined entry is ever read
  task automatic feed_byte(input logic [7:0] b);
    if (b != 8'h00 && !b[7] && !map_loaded[b[6:0]])
      load_entry(b[6:0], 8'($urandom_range(0, 255)));
    send_word(mshm_pkg::ACT_BYTE, b, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)));
  endtask

  // mostly short strings, now and then a long one; loads mixed in as noise
  task automatic random_string(input int max_len);
    int len;
    int pick;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, max_len);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        feed_byte(8'($urandom_range(1, 127)));
      else if (pick < 9)
        feed_byte(8'($urandom_range(128, 255)));
      else
        load_entry(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
    end
    feed_byte(8'h00);
  endtask

  // sender pauses until every due result has come back, then lets the
  // divider back end run dry before anything else happens
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left  = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [31:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // receiver: stall rate changes after stretches of random length, with stretches of
  // no stalling, plus one long hold-off on request so the queue fills up
  initial begin
    int stall_pct;
    int pattern_left;
    bit hold_taken;
    m_tready    <= 1'b0;
    stall_pct    = 0;
    pattern_left = 0;
    hold_taken   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready  <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (pattern_left <= 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] divisor_plan [PHASES];
    int          phase_end;
    int          base;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= 24'd0;
    s_tuser    <= 1'b0;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= 32'd0;
    hold_req   <= 1'b0;
    words_sent  = 0;
    burst_left  = 0;
    idle_style  = 0;
    foreach (map_loaded[i]) map_loaded[i] = 1'b0;

    // extremes first, then a random small and a random full-range modulus, then two fixed ones
    divisor_plan[0] = 32'hFFFFFFFF;
    divisor_plan[1] = 32'd1;
    divisor_plan[2] = 32'd2;
    divisor_plan[3] = 32'h80000000;
    divisor_plan[4] = 32'($urandom_range(3, 1000));
    divisor_plan[5] = $urandom;
    if (divisor_plan[5] == 32'd0) divisor_plan[5] = 32'd1;
    divisor_plan[6] = 32'h00010000;
    divisor_plan[7] = 32'd7;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, divisor still at its reset value
    load_entry(7'd0, 8'h00);
    load_entry(7'd127, 8'hFF);
    load_entry(7'd1, 8'h80);
    load_entry(7'd65, 8'h41);
    // empty string
    feed_byte(8'h00);
    // lowest and highest mapped bytes
    feed_byte(8'h7F);
    feed_byte(8'h01);
    feed_byte(8'h00);
    // both ends of the sign-extended range
    feed_byte(8'h80);
    feed_byte(8'hFF);
    feed_byte(8'h00);
    // map reload in mid-string, carrying a zero byte that must not terminate
    feed_byte(8'h41);
    send_word(mshm_pkg::ACT_LOAD, 8'h00, 7'd127, 8'h01);
    feed_byte(8'h7F);
    feed_byte(8'h00);
    // byte words with the unused index and value fields all set, terminator included
    send_word(mshm_pkg::ACT_BYTE, 8'hFF, 7'h7F, 8'hFF);
    send_word(mshm_pkg::ACT_BYTE, 8'h00, 7'h7F, 8'hFF);
    drain_results();

    // random part, one divisor setting per phase
    base = words_sent;
    for (int p = 0; p < PHASES; p++) begin
      write_divisor(divisor_plan[p]);
      idle_style = (p == 2) ? 0 : $urandom_range(0, 2);
      phase_end  = base + (ITEM_TARGET - base) * (p + 1) / PHASES;
      if (p == 2) begin
        // long receiver hold-off while strings keep coming, so input stalls
        hold_req <= 1'b1;
        for (int s = 0; s < 20; s++) random_string(4);
      end
      while (words_sent < phase_end) begin
        random_string(10);
        // near the end of phase 4, now and then a pause until every due result is back
        if (p == 4 && words_sent >= phase_end - (phase_end - base) / 16 / PHASES * 8)
          if ($urandom_range(0, 3) == 0) drain_results();
      end
      drain_results();
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### mapped_string_hash_mod.f
+incdir+sv
sv/mshm_pkg.sv
sv/mshm_ram.sv
sv/mshm_front.sv
sv/mshm_queue.sv
sv/mshm_back.sv
sv/mapped_string_hash_mod.sv
dv/mshm_checker.sv
dv/testbench.sv
